// ----- src/rvx_pkg.sv -----
// ----------------------------------------------------------------------------
// rvx_pkg
// shared types and encodings of the rv64im subset execute unit
// ----------------------------------------------------------------------------
package rvx_pkg;

    localparam int          DefRegisterCount = 32;
    localparam logic [63:0] DefStartAddress  = 64'h0000_0000_8000_0000;

    // major opcodes
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_SYSTEM = 7'h73;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_IMM32  = 7'h1b;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_REG32  = 7'h3b;

    localparam logic [31:0] INSN_EBREAK = 32'h0010_0073;

    // funct3 codes
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_DIV  = 3'd4;
    localparam logic [2:0] F3_DIVU = 3'd5;
    localparam logic [2:0] F3_REM  = 3'd6;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_B  = 3'd0;
    localparam logic [2:0] F3_H  = 3'd1;
    localparam logic [2:0] F3_W  = 3'd2;
    localparam logic [2:0] F3_D  = 3'd3;
    localparam logic [2:0] F3_BU = 3'd4;
    localparam logic [2:0] F3_HU = 3'd5;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MUL  = 7'h01;
    localparam logic [5:0] F6_SRL  = 6'h00;
    localparam logic [5:0] F6_SRA  = 6'h10;

    localparam logic       KIND_INSN = 1'b0;
    localparam logic       KIND_LOAD = 1'b1;

    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_HALT    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [3:0] SZ_NONE = 4'd0;
    localparam logic [3:0] SZ_B    = 4'd1;
    localparam logic [3:0] SZ_H    = 4'd2;
    localparam logic [3:0] SZ_W    = 4'd4;
    localparam logic [3:0] SZ_D    = 4'd8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_WB
    } t_state;

    // everything one item decides, committed at writeback
    typedef struct packed {
        logic [63:0] npc;
        logic        pc_we;
        logic [1:0]  req;
        logic [63:0] addr;
        logic [3:0]  size;
        logic [63:0] sdata;
        logic [1:0]  status;
        logic [63:0] exitc;
        logic        wb;
        logic [4:0]  wbidx;
        logic [63:0] wbval;
        logic        set_halt;
        logic        set_pend;
        logic        clr_pend;
        logic        pend_signed;
    } t_bundle;

    typedef struct packed {
        logic [63:0] next_pc;
        logic [1:0]  mem_request;
        logic [63:0] mem_address;
        logic [3:0]  mem_size;
        logic [63:0] store_data;
        logic [1:0]  status;
        logic [63:0] exit_code;
        logic        write_enable;
        logic [4:0]  dest_index;
        logic [63:0] dest_value;
    } t_result;

    function automatic logic [63:0] sext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

// ----- src/rvx_ifs.sv -----
// ----------------------------------------------------------------------------
// rvx channel interfaces
// valid/ready channels for instruction or load data in, step results out
// ----------------------------------------------------------------------------
interface rvx_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] instruction;
    logic [63:0] load_data;

    modport source (output valid, kind, instruction, load_data, input ready);
    modport sink   (input valid, kind, instruction, load_data, output ready);
endinterface

interface rvx_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] next_pc;
    logic [1:0]  mem_request;
    logic [63:0] mem_address;
    logic [3:0]  mem_size;
    logic [63:0] store_data;
    logic [1:0]  status;
    logic [63:0] exit_code;
    logic        write_enable;
    logic [4:0]  dest_index;
    logic [63:0] dest_value;

    modport source (output valid, next_pc, mem_request, mem_address, mem_size, store_data,
                    status, exit_code, write_enable, dest_index, dest_value, input ready);
    modport sink   (input valid, next_pc, mem_request, mem_address, mem_size, store_data,
                    status, exit_code, write_enable, dest_index, dest_value, output ready);
endinterface

// ----- src/rv64im_subset_execute_unit.sv -----
// ----------------------------------------------------------------------------
// rv64im_subset_execute_unit
// executes one rv64im subset instruction or one load return per item
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  i_in     | in  | valid / ready        | kind, instruction, load_data
//  o_out    | out | valid / ready        | next_pc, mem request, status, reg write
//  apb      | in  | psel, penable, pwrite| start_address at byte address 0
//
//  alu, branch, jump, load and store items pass through these steps:
//  accept with register file read, read data back and execute, writeback
//  mul and mulw use the shared 32x32 multiplier (three partial products)
//  divu, divw and remw go through the radix-2 divider
//  reset clears the register file valid bits at once, so no clearing pass
//  a finished result waits in the output register; the next item is accepted
//  meanwhile and its writeback holds until the output register is free
// ----------------------------------------------------------------------------
module rv64im_subset_execute_unit
    import rvx_pkg::*;
#(
    parameter int REGISTER_COUNT = DefRegisterCount
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rvx_in_if.sink      i_in,
    rvx_out_if.source   o_out,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [63:0] i_pwdata,
    output logic [63:0] o_prdata,
    output logic        o_pready
);
    localparam int IW = $clog2(REGISTER_COUNT);

    t_state                    r_state, n_state;
    logic [63:0]               r_start;
    logic [63:0]               r_pc;
    logic                      r_halted;
    logic                      r_pend;
    logic [4:0]                r_pend_dest;
    logic [3:0]                r_pend_size;
    logic                      r_pend_signed;
    logic                      r_kind;
    logic [31:0]               r_ins;
    logic [63:0]               r_ldata;
    logic [REGISTER_COUNT-1:0] r_valid;
    logic                      r_a_live, r_b_live;
    t_bundle                   r_bnd, n_bnd;
    t_result                   r_out;
    logic                      r_ovalid;
    logic [1:0]                r_mcnt;
    logic [63:0]               r_prod, r_acc;

    logic        accept;
    logic        cfg_wr;
    logic [31:0] rd_word;
    logic [4:0]  rd_a_idx, rd_b_idx;
    logic [63:0] ram_a_q, ram_b_q, a, b;
    logic        rf_we;
    logic        go_mul, go_div;
    logic        div_start;
    logic [63:0] div_dnd, div_dsr, div_q, div_r;
    logic        div_done;
    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_sum;
    logic        commit;

    // decode fields of the held instruction
    logic [6:0]  op;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [5:0]  f6;
    logic [5:0]  sh6;
    logic [4:0]  sh5;
    logic [63:0] imm_i, imm_s, imm_b, imm_j, imm_u;
    logic        na, nb;
    logic [31:0] ma, mb;

    function automatic logic idx_ok(input logic [4:0] idx);
        return (idx != 5'd0) && (32'(idx) < REGISTER_COUNT);
    endfunction

    assign accept   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign cfg_wr   = i_psel && i_penable && i_pwrite && !i_paddr[3];
    assign o_pready = 1'b1;
    assign o_prdata = i_paddr[3] ? 64'd0 : r_start;

    // register file reads; port a also serves a0 for halt reporting
    // the read address follows the held word while an item is in flight
    assign rd_word  = (r_state == S_IDLE) ? i_in.instruction : r_ins;
    assign rd_a_idx = (r_halted || rd_word == INSN_EBREAK) ? 5'd10 : rd_word[19:15];
    assign rd_b_idx = rd_word[24:20];

    assign commit = (r_state == S_WB) && (!r_ovalid || o_out.ready);
    assign rf_we  = commit && r_bnd.wb && idx_ok(r_bnd.wbidx);

    rvx_ram #(.WIDTH(64), .DEPTH(REGISTER_COUNT)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_bnd.wbidx[IW-1:0]),
        .i_wdata (r_bnd.wbval),
        .i_raddr (rd_a_idx[IW-1:0]),
        .o_rdata (ram_a_q)
    );

    rvx_ram #(.WIDTH(64), .DEPTH(REGISTER_COUNT)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_bnd.wbidx[IW-1:0]),
        .i_wdata (r_bnd.wbval),
        .i_raddr (rd_b_idx[IW-1:0]),
        .o_rdata (ram_b_q)
    );

    // never-written entries and x0 read as zero
    assign a = r_a_live ? ram_a_q : 64'd0;
    assign b = r_b_live ? ram_b_q : 64'd0;

    assign op    = r_ins[6:0];
    assign f3    = r_ins[14:12];
    assign f7    = r_ins[31:25];
    assign f6    = r_ins[31:26];
    assign sh6   = r_ins[25:20];
    assign sh5   = r_ins[24:20];
    assign imm_i = {{52{r_ins[31]}}, r_ins[31:20]};
    assign imm_s = {{52{r_ins[31]}}, r_ins[31:25], r_ins[11:7]};
    assign imm_b = {{52{r_ins[31]}}, r_ins[7], r_ins[30:25], r_ins[11:8], 1'b0};
    assign imm_j = {{44{r_ins[31]}}, r_ins[19:12], r_ins[20], r_ins[30:21], 1'b0};
    assign imm_u = {{32{r_ins[31]}}, r_ins[31:12], 12'd0};

    // signed 32-bit divide works on magnitudes
    assign na = a[31];
    assign nb = b[31];
    assign ma = na ? (32'd0 - a[31:0]) : a[31:0];
    assign mb = nb ? (32'd0 - b[31:0]) : b[31:0];

    // execute: decide the whole step from the held item and the operands
    always_comb begin
        logic        ok, writes, ebrk, taken;
        logic [63:0] res, npc, seq, ext;
        logic [3:0]  size;
        ok     = 1'b1;
        writes = 1'b1;
        ebrk   = 1'b0;
        taken  = 1'b0;
        res    = 64'd0;
        seq    = r_pc + 64'd4;
        npc    = seq;
        ext    = r_ldata;
        size   = SZ_NONE;
        go_mul = 1'b0;
        go_div = 1'b0;
        n_bnd  = '0;
        n_bnd.npc = r_pc;

        if (r_halted) begin
            n_bnd.status = ST_HALT;
            n_bnd.exitc  = a;
        end else if (r_kind == KIND_LOAD) begin
            if (r_pend) begin
                case (r_pend_size)
                    SZ_B:    ext = r_pend_signed ? {{56{r_ldata[7]}}, r_ldata[7:0]}
                                                 : {56'd0, r_ldata[7:0]};
                    SZ_H:    ext = r_pend_signed ? {{48{r_ldata[15]}}, r_ldata[15:0]}
                                                 : {48'd0, r_ldata[15:0]};
                    SZ_W:    ext = r_pend_signed ? sext32(r_ldata[31:0])
                                                 : {32'd0, r_ldata[31:0]};
                    default: ext = r_ldata;
                endcase
                n_bnd.wb       = 1'b1;
                n_bnd.wbidx    = r_pend_dest;
                n_bnd.wbval    = ext;
                n_bnd.clr_pend = 1'b1;
            end
        end else if (!r_pend) begin
            unique case (op)
                OP_LUI:   res = imm_u;
                OP_AUIPC: res = r_pc + imm_u;
                OP_JAL: begin
                    res = seq;
                    npc = r_pc + imm_j;
                end
                OP_JALR: begin
                    if (f3 != F3_ADD) begin
                        ok = 1'b0;
                    end else begin
                        npc = (a + imm_i) & ~64'd1;
                        res = seq;
                    end
                end
                OP_BRANCH: begin
                    writes = 1'b0;
                    case (f3)
                        F3_BEQ:  taken = (a == b);
                        F3_BNE:  taken = (a != b);
                        F3_BLT:  taken = ($signed(a) < $signed(b));
                        F3_BGE:  taken = !($signed(a) < $signed(b));
                        F3_BLTU: taken = (a < b);
                        F3_BGEU: taken = (a >= b);
                        default: ok = 1'b0;
                    endcase
                    if (taken) begin
                        npc = r_pc + imm_b;
                    end
                end
                OP_LOAD: begin
                    writes = 1'b0;
                    case (f3)
                        F3_D:    begin size = SZ_D; n_bnd.pend_signed = 1'b1; end
                        F3_W:    begin size = SZ_W; n_bnd.pend_signed = 1'b1; end
                        F3_H:    begin size = SZ_H; n_bnd.pend_signed = 1'b1; end
                        F3_HU:   size = SZ_H;
                        F3_BU:   size = SZ_B;
                        default: ok = 1'b0;
                    endcase
                    n_bnd.req      = REQ_READ;
                    n_bnd.addr     = a + imm_i;
                    n_bnd.set_pend = 1'b1;
                    n_bnd.wbidx    = r_ins[11:7];
                end
                OP_STORE: begin
                    writes = 1'b0;
                    case (f3)
                        F3_D:    size = SZ_D;
                        F3_W:    size = SZ_W;
                        F3_H:    size = SZ_H;
                        F3_B:    size = SZ_B;
                        default: ok = 1'b0;
                    endcase
                    n_bnd.req   = REQ_WRITE;
                    n_bnd.addr  = a + imm_s;
                    n_bnd.sdata = b;
                end
                OP_SYSTEM: begin
                    writes = 1'b0;
                    if (r_ins == INSN_EBREAK) begin
                        ebrk = 1'b1;
                    end else begin
                        ok = 1'b0;
                    end
                end
                OP_IMM: begin
                    case (f3)
                        F3_ADD:  res = a + imm_i;
                        F3_SLL:  begin
                            if (f6 == F6_SRL) res = a << sh6; else ok = 1'b0;
                        end
                        F3_SLT:  res = {63'd0, $signed(a) < $signed(imm_i)};
                        F3_SLTU: res = {63'd0, a < imm_i};
                        F3_XOR:  res = a ^ imm_i;
                        F3_SR:   begin
                            if (f6 == F6_SRL)      res = a >> sh6;
                            else if (f6 == F6_SRA) res = $signed(a) >>> sh6;
                            else                   ok = 1'b0;
                        end
                        F3_AND:  res = a & imm_i;
                        default: ok = 1'b0;
                    endcase
                end
                OP_IMM32: begin
                    if (f3 == F3_ADD)                       res = sext32(a[31:0] + imm_i[31:0]);
                    else if (f3 == F3_SLL && f7 == F7_BASE) res = sext32(a[31:0] << sh5);
                    else if (f3 == F3_SR && f7 == F7_BASE)  res = sext32(a[31:0] >> sh5);
                    else if (f3 == F3_SR && f7 == F7_ALT)
                        res = sext32($signed(a[31:0]) >>> sh5);
                    else                                    ok = 1'b0;
                end
                OP_REG: begin
                    if (f7 == F7_BASE && f3 == F3_ADD)       res = a + b;
                    else if (f7 == F7_BASE && f3 == F3_SLT)  res = {63'd0, $signed(a) < $signed(b)};
                    else if (f7 == F7_BASE && f3 == F3_SLTU) res = {63'd0, a < b};
                    else if (f7 == F7_BASE && f3 == F3_OR)   res = a | b;
                    else if (f7 == F7_BASE && f3 == F3_AND)  res = a & b;
                    else if (f7 == F7_ALT && f3 == F3_ADD)   res = a - b;
                    else if (f7 == F7_MUL && f3 == F3_ADD)   go_mul = 1'b1;
                    else if (f7 == F7_MUL && f3 == F3_DIVU)  go_div = 1'b1;
                    else                                     ok = 1'b0;
                end
                OP_REG32: begin
                    if (f7 == F7_BASE && f3 == F3_ADD)      res = sext32(a[31:0] + b[31:0]);
                    else if (f7 == F7_BASE && f3 == F3_SLL) res = sext32(a[31:0] << b[4:0]);
                    else if (f7 == F7_BASE && f3 == F3_SR)  res = sext32(a[31:0] >> b[4:0]);
                    else if (f7 == F7_ALT && f3 == F3_ADD)  res = sext32(a[31:0] - b[31:0]);
                    else if (f7 == F7_ALT && f3 == F3_SR)
                        res = sext32($signed(a[31:0]) >>> b[4:0]);
                    else if (f7 == F7_MUL && f3 == F3_ADD)  go_mul = 1'b1;
                    else if (f7 == F7_MUL && (f3 == F3_DIV || f3 == F3_REM)) go_div = 1'b1;
                    else                                    ok = 1'b0;
                end
                default: ok = 1'b0;
            endcase

            if (!ok) begin
                n_bnd          = '0;
                n_bnd.npc      = r_pc;
                n_bnd.status   = ST_INVALID;
                go_mul         = 1'b0;
                go_div         = 1'b0;
            end else begin
                n_bnd.size  = size;
                n_bnd.npc   = npc;
                n_bnd.pc_we = 1'b1;
                if (writes) begin
                    n_bnd.wb    = 1'b1;
                    n_bnd.wbidx = r_ins[11:7];
                    n_bnd.wbval = res;
                end
                if (ebrk) begin
                    n_bnd.status   = ST_HALT;
                    n_bnd.exitc    = a;
                    n_bnd.set_halt = 1'b1;
                end
            end
        end
    end

    // multiplier: low 64 bits from three 32x32 partial products
    always_comb begin
        case (r_mcnt)
            2'd0:    begin mul_x = a[31:0];  mul_y = b[31:0];  end
            2'd1:    begin mul_x = a[31:0];  mul_y = b[63:32]; end
            default: begin mul_x = a[63:32]; mul_y = b[31:0];  end
        endcase
    end
    assign mul_sum = r_acc + {r_prod[31:0], 32'd0};

    // divider operands: divu uses full values, divw and remw their magnitudes
    assign div_start = (r_state == S_EXEC) && go_div;
    assign div_dnd   = (op == OP_REG) ? a : {32'd0, ma};
    assign div_dsr   = (op == OP_REG) ? b : {32'd0, mb};

    rvx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dnd),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_quo      (div_q),
        .o_rem      (div_r)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_EXEC;
            S_EXEC: begin
                if (go_mul)      n_state = S_MUL;
                else if (go_div) n_state = S_DIV;
                else             n_state = S_WB;
            end
            S_MUL:  if (r_mcnt == 2'd3) n_state = S_WB;
            S_DIV:  if (div_done) n_state = S_WB;
            S_WB:   if (commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start       <= DefStartAddress;
            r_pc          <= DefStartAddress;
            r_halted      <= 1'b0;
            r_pend        <= 1'b0;
            r_pend_dest   <= '0;
            r_pend_size   <= '0;
            r_pend_signed <= 1'b0;
            r_valid       <= '0;
            r_ovalid      <= 1'b0;
            r_mcnt        <= '0;
        end else begin
            if (cfg_wr) begin
                r_start <= i_pwdata;
                r_pc    <= i_pwdata;
            end
            if (r_state == S_EXEC) begin
                r_mcnt <= '0;
            end else if (r_state == S_MUL) begin
                r_mcnt <= r_mcnt + 2'd1;
            end
            if (commit) begin
                r_ovalid <= 1'b1;
                if (r_bnd.pc_we) r_pc <= r_bnd.npc;
                if (r_bnd.set_halt) r_halted <= 1'b1;
                if (r_bnd.clr_pend) r_pend <= 1'b0;
                if (r_bnd.set_pend) begin
                    r_pend        <= 1'b1;
                    r_pend_dest   <= r_bnd.wbidx;
                    r_pend_size   <= r_bnd.size;
                    r_pend_signed <= r_bnd.pend_signed;
                end
                if (rf_we) r_valid[r_bnd.wbidx[IW-1:0]] <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= i_in.kind;
            r_ins    <= i_in.instruction;
            r_ldata  <= i_in.load_data;
            r_a_live <= idx_ok(rd_a_idx) && r_valid[rd_a_idx[IW-1:0]];
            r_b_live <= idx_ok(rd_b_idx) && r_valid[rd_b_idx[IW-1:0]];
        end
        if (r_state == S_MUL) begin
            r_prod <= mul_x * mul_y;
        end
        case (r_state)
            S_EXEC: r_bnd <= n_bnd;
            S_MUL: begin
                if (r_mcnt == 2'd1) begin
                    r_acc <= r_prod;
                end else if (r_mcnt == 2'd2) begin
                    r_acc <= mul_sum;
                end else if (r_mcnt == 2'd3) begin
                    r_bnd.wbval <= (op == OP_REG) ? mul_sum : sext32(mul_sum[31:0]);
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (op == OP_REG) begin
                        r_bnd.wbval <= div_q;
                    end else if (f3 == F3_DIV) begin
                        r_bnd.wbval <= (b[31:0] == 32'd0) ? ~64'd0 :
                            sext32((na != nb) ? (32'd0 - div_q[31:0]) : div_q[31:0]);
                    end else begin
                        r_bnd.wbval <= (b[31:0] == 32'd0) ? sext32(a[31:0]) :
                            sext32(na ? (32'd0 - div_r[31:0]) : div_r[31:0]);
                    end
                end
            end
            default: ;
        endcase
        if (commit) begin
            r_out.next_pc      <= r_bnd.npc;
            r_out.mem_request  <= r_bnd.req;
            r_out.mem_address  <= r_bnd.addr;
            r_out.mem_size     <= (r_bnd.req == REQ_NONE) ? SZ_NONE : r_bnd.size;
            r_out.store_data   <= r_bnd.sdata;
            r_out.status       <= r_bnd.status;
            r_out.exit_code    <= r_bnd.exitc;
            r_out.write_enable <= rf_we;
            r_out.dest_index   <= rf_we ? r_bnd.wbidx : 5'd0;
            r_out.dest_value   <= rf_we ? r_bnd.wbval : 64'd0;
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.next_pc      = r_out.next_pc;
    assign o_out.mem_request  = r_out.mem_request;
    assign o_out.mem_address  = r_out.mem_address;
    assign o_out.mem_size     = r_out.mem_size;
    assign o_out.store_data   = r_out.store_data;
    assign o_out.status       = r_out.status;
    assign o_out.exit_code    = r_out.exit_code;
    assign o_out.write_enable = r_out.write_enable;
    assign o_out.dest_index   = r_out.dest_index;
    assign o_out.dest_value   = r_out.dest_value;
endmodule

// ----- src/rvx_ram.sv -----
// ----------------------------------------------------------------------------
// rvx_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rvx_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

// ----- src/rvx_div.sv -----
// ----------------------------------------------------------------------------
// rvx_div
// 64-bit unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rvx_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quo,
    output logic [63:0] o_rem
);
    logic [64:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_dsr;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] shifted;
    logic [64:0] trial;

    assign shifted = {r_rem[63:0], r_quo[63]};
    assign trial   = shifted - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            if (!trial[64]) begin
                r_rem <= trial;
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[63:0];
endmodule
